### rtl/core/mrs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrs_pkg
// shared types and codes of the multipath route selector
// ----------------------------------------------------------------------------
package mrs_pkg;

    localparam int unsigned TICK_W = 48;
    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    typedef enum logic [2:0] {
        FN_TICK   = 3'd0,
        FN_ADD    = 3'd1,
        FN_REMOVE = 3'd2,
        FN_BEST   = 3'd3,
        FN_HAS    = 3'd4,
        FN_LIST   = 3'd5,
        FN_PURGE  = 3'd6,
        FN_NONE   = 3'd7
    } t_func;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_DEST_FULL = 2'd2;
    localparam logic [1:0] ST_PATH_FULL = 2'd3;

    typedef struct packed {
        t_func       func;
        logic [31:0] destination;
        logic [31:0] next_hop;
        logic [7:0]  hop_count;
        logic [31:0] lifetime;
    } t_req;

    typedef struct packed {
        logic [1:0]        status;
        logic [31:0]       next_hop;
        logic [7:0]        hop_count;
        logic [TICK_W-1:0] expiry;
        logic [2:0]        live_paths;
        logic              last;
    } t_res;

endpackage : mrs_pkg
`default_nettype wire

### rtl/core/mrs_req_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrs_req_fifo
// front part: two-entry request queue between the ports and the engine
// ----------------------------------------------------------------------------
module mrs_req_fifo (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    output logic          o_ready,
    input  mrs_pkg::t_req i_req,
    output logic          o_valid,
    input  wire           i_ready,
    output mrs_pkg::t_req o_req
);
    mrs_pkg::t_req r_mem [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          w_push, w_pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_mem[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_req;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule : mrs_req_fifo
`default_nettype wire

### rtl/core/mrs_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mrs_engine
// back part: walks the destination table and path slots for one request
// ----------------------------------------------------------------------------
module mrs_engine #(
    parameter int unsigned DEST_SLOTS = 16,
    parameter int unsigned PATH_SLOTS = 4
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_valid,
    output logic          o_ready,
    input  mrs_pkg::t_req i_req,
    output logic          o_valid,
    input  wire           i_ready,
    output mrs_pkg::t_res o_res
);
    localparam int unsigned DW = (DEST_SLOTS > 1) ? $clog2(DEST_SLOTS) : 1;
    localparam int unsigned PW = (PATH_SLOTS > 1) ? $clog2(PATH_SLOTS) : 1;
    localparam int unsigned CW = $clog2(PATH_SLOTS + 1);
    localparam int unsigned DCW = $clog2(DEST_SLOTS + 1);
    localparam logic [CW-1:0] PMAX = CW'(PATH_SLOTS);
    localparam logic [CW-1:0] LCAP = CW'(4);

    typedef enum logic [9:0] {
        S_IDLE   = 10'b0000000001,
        S_FIND   = 10'b0000000010,
        S_PRUNE  = 10'b0000000100,
        S_RMV    = 10'b0000001000,
        S_ALLOC  = 10'b0000010000,
        S_SCAN   = 10'b0000100000,
        S_DO     = 10'b0001000000,
        S_BEST   = 10'b0010000000,
        S_LIST   = 10'b0100000000,
        S_OUT    = 10'b1000000000
    } t_state;

    t_state r_state;
    mrs_pkg::t_req r_req;
    logic [mrs_pkg::TICK_W-1:0] r_tick;
    logic [DEST_SLOTS-1:0] r_used;
    logic [31:0] r_daddr [DEST_SLOTS];
    logic [CW-1:0] r_held [DEST_SLOTS];
    logic [31:0] r_nh  [DEST_SLOTS*PATH_SLOTS];
    logic [7:0]  r_hop [DEST_SLOTS*PATH_SLOTS];
    logic [mrs_pkg::TICK_W-1:0] r_exp [DEST_SLOTS*PATH_SLOTS];

    logic [DCW-1:0] r_d;        // destination index being walked
    logic           r_all;      // prune every destination
    logic           r_ph;       // path read issued, data valid next cycle
    logic [CW-1:0]  r_rd, r_wr; // path read and write pointers
    logic [CW-1:0]  r_n;
    logic [PW-1:0]  r_best;
    logic [7:0]     r_bhop;
    mrs_pkg::t_res  r_res;
    logic           r_ovalid;
    logic [31:0]    r_q_nh;
    logic [7:0]     r_q_hop;
    logic [mrs_pkg::TICK_W-1:0] r_q_exp;

    logic [DW-1:0] w_d;
    logic [DW+PW-1:0] w_ra, w_wa;
    logic w_keep;
    logic [mrs_pkg::TICK_W:0] w_sum;
    logic [mrs_pkg::TICK_W-1:0] w_expn;
    logic w_lst;
    logic w_emit;

    assign w_d  = r_d[DW-1:0];
    assign w_ra = (DW+PW)'(w_d) * (DW+PW)'(PATH_SLOTS) + (DW+PW)'(r_rd);
    assign w_wa = (DW+PW)'(w_d) * (DW+PW)'(PATH_SLOTS) + (DW+PW)'(r_wr);
    assign w_keep = (r_q_exp > r_tick) &&
                    !((r_state == S_RMV) && (r_q_nh == r_req.next_hop));
    assign w_sum  = {1'b0, r_tick} + (mrs_pkg::TICK_W+1)'(r_req.lifetime);
    assign w_expn = w_sum[mrs_pkg::TICK_W] ? mrs_pkg::TICK_MAX
                                           : w_sum[mrs_pkg::TICK_W-1:0];
    assign w_lst  = (r_req.func == mrs_pkg::FN_BEST) ||
                    (r_rd + 1'b1 == r_n) || (r_rd + 1'b1 == LCAP);
    assign w_emit = (((r_state == S_LIST) && r_ph) || (r_state == S_OUT)) &&
                    (!r_ovalid || i_ready);

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_res   = r_res;

    function automatic mrs_pkg::t_res mk(input logic [1:0] st, input logic [31:0] nh,
                                         input logic [7:0] hc,
                                         input logic [mrs_pkg::TICK_W-1:0] ex,
                                         input logic [CW-1:0] lv, input logic la);
        mrs_pkg::t_res r;
        r.status     = st;
        r.next_hop   = nh;
        r.hop_count  = hc;
        r.expiry     = ex;
        r.live_paths = 3'(lv);
        r.last       = la;
        return r;
    endfunction

    // registered path read
    always_ff @(posedge i_clk) begin
        r_q_nh  <= r_nh[w_ra];
        r_q_hop <= r_hop[w_ra];
        r_q_exp <= r_exp[w_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_tick   <= '0;
            r_used   <= '0;
            r_ovalid <= 1'b0;
            r_ph     <= 1'b0;
            for (int i = 0; i < DEST_SLOTS; i++) r_held[i] <= '0;
        end else begin
            if (r_ovalid && i_ready && !w_emit) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_req   <= i_req;
                        r_d     <= '0;
                        r_ph    <= 1'b0;
                        r_all   <= (i_req.func == mrs_pkg::FN_PURGE);
                        unique case (i_req.func)
                            mrs_pkg::FN_TICK: begin
                                r_res <= mk(mrs_pkg::ST_OK, '0, '0,
                                    (r_tick == mrs_pkg::TICK_MAX) ? r_tick : r_tick + 1'b1,
                                    '0, 1'b1);
                                if (r_tick != mrs_pkg::TICK_MAX) r_tick <= r_tick + 1'b1;
                                r_state <= S_OUT;
                            end
                            mrs_pkg::FN_PURGE: begin
                                r_rd    <= '0;
                                r_wr    <= '0;
                                r_state <= S_PRUNE;
                            end
                            mrs_pkg::FN_NONE: begin
                                r_res   <= mk(mrs_pkg::ST_NOT_FOUND, '0, '0, '0, '0, 1'b1);
                                r_state <= S_OUT;
                            end
                            default: r_state <= S_FIND;
                        endcase
                    end
                end
                S_FIND: begin
                    if (r_used[w_d] && r_daddr[w_d] == r_req.destination) begin
                        r_rd    <= '0;
                        r_wr    <= '0;
                        r_state <= (r_req.func == mrs_pkg::FN_REMOVE) ? S_RMV : S_PRUNE;
                    end else if (r_d == DCW'(DEST_SLOTS - 1)) begin
                        if (r_req.func == mrs_pkg::FN_ADD) begin
                            r_all   <= 1'b1;
                            r_d     <= '0;
                            r_rd    <= '0;
                            r_wr    <= '0;
                            r_state <= S_PRUNE;
                        end else begin
                            r_res   <= mk(mrs_pkg::ST_NOT_FOUND, '0, '0, '0, '0, 1'b1);
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_d <= r_d + 1'b1;
                    end
                end
                S_RMV, S_PRUNE: begin
                    // each path is read first and, if kept, written back, compacting in place
                    if (!r_all || r_used[w_d]) begin
                        if (r_rd < r_held[w_d]) begin
                            if (!r_ph) begin
                                r_ph <= 1'b1;
                            end else begin
                                if (w_keep) begin
                                    r_nh[w_wa]  <= r_q_nh;
                                    r_hop[w_wa] <= r_q_hop;
                                    r_exp[w_wa] <= r_q_exp;
                                    r_wr <= r_wr + 1'b1;
                                end
                                r_rd <= r_rd + 1'b1;
                                r_ph <= 1'b0;
                            end
                        end else if (r_state == S_RMV) begin
                            r_held[w_d] <= r_wr;
                            r_rd    <= '0;
                            r_wr    <= '0;
                            r_state <= S_PRUNE;
                        end else begin
                            r_held[w_d] <= r_wr;
                            if (r_wr == '0) r_used[w_d] <= 1'b0;
                            r_n <= r_wr;
                            if (r_all) begin
                                r_rd <= '0;
                                r_wr <= '0;
                                if (r_d == DCW'(DEST_SLOTS - 1)) begin
                                    r_d <= '0;
                                    if (r_req.func == mrs_pkg::FN_PURGE) begin
                                        r_res <= mk(mrs_pkg::ST_OK, '0, '0, '0, '0, 1'b1);
                                        r_state <= S_OUT;
                                    end else begin
                                        r_state <= S_ALLOC;
                                    end
                                end else begin
                                    r_d <= r_d + 1'b1;
                                end
                            end else begin
                                r_state <= S_DO;
                            end
                        end
                    end else if (r_d == DCW'(DEST_SLOTS - 1)) begin
                        r_d <= '0;
                        if (r_req.func == mrs_pkg::FN_PURGE) begin
                            r_res <= mk(mrs_pkg::ST_OK, '0, '0, '0, '0, 1'b1);
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_ALLOC;
                        end
                    end else begin
                        r_d <= r_d + 1'b1;
                    end
                end
                S_ALLOC: begin
                    if (!r_used[w_d]) begin
                        r_daddr[w_d] <= r_req.destination;
                        r_held[w_d]  <= '0;
                        r_n     <= '0;
                        r_rd    <= '0;
                        r_state <= S_SCAN;
                    end else if (r_d == DCW'(DEST_SLOTS - 1)) begin
                        r_res   <= mk(mrs_pkg::ST_DEST_FULL, '0, '0, '0, '0, 1'b1);
                        r_state <= S_OUT;
                    end else begin
                        r_d <= r_d + 1'b1;
                    end
                end
                S_DO: begin
                    r_rd <= '0;
                    r_best <= '0;
                    unique case (r_req.func)
                        mrs_pkg::FN_ADD: r_state <= S_SCAN;
                        mrs_pkg::FN_REMOVE: begin
                            r_res   <= mk(mrs_pkg::ST_OK, '0, '0, '0, r_n, 1'b1);
                            r_state <= S_OUT;
                        end
                        default: begin
                            if (r_n == '0) begin
                                r_res <= mk(mrs_pkg::ST_NOT_FOUND, '0, '0, '0, '0, 1'b1);
                                r_state <= S_OUT;
                            end else if (r_req.func == mrs_pkg::FN_HAS) begin
                                r_res <= mk(mrs_pkg::ST_OK, '0, '0, '0, r_n, 1'b1);
                                r_state <= S_OUT;
                            end else if (r_req.func == mrs_pkg::FN_BEST) begin
                                r_state <= S_BEST;
                            end else begin
                                r_state <= S_LIST;
                            end
                        end
                    endcase
                end
                S_SCAN: begin
                    // add: match next hop or append
                    if (r_rd < r_n && !r_ph) begin
                        r_ph <= 1'b1;
                    end else if (r_rd < r_n && r_q_nh != r_req.next_hop) begin
                        r_rd <= r_rd + 1'b1;
                        r_ph <= 1'b0;
                    end else if (r_rd == r_n && r_n >= PMAX) begin
                        r_used[w_d] <= 1'b1;
                        r_res   <= mk(mrs_pkg::ST_PATH_FULL, '0, '0, '0, r_n, 1'b1);
                        r_state <= S_OUT;
                    end else begin
                        r_used[w_d] <= 1'b1;
                        r_nh[w_ra]  <= r_req.next_hop;
                        r_hop[w_ra] <= r_req.hop_count;
                        r_exp[w_ra] <= w_expn;
                        r_ph <= 1'b0;
                        if (r_rd == r_n) begin
                            r_held[w_d] <= r_n + 1'b1;
                        end
                        r_res <= mk(mrs_pkg::ST_OK, r_req.next_hop, r_req.hop_count,
                                    w_expn, (r_rd == r_n) ? r_n + 1'b1 : r_n, 1'b1);
                        r_state <= S_OUT;
                    end
                end
                S_BEST: begin
                    if (r_rd < r_n) begin
                        if (!r_ph) begin
                            r_ph <= 1'b1;
                        end else begin
                            if (r_rd == '0 || r_q_hop < r_bhop) begin
                                r_best <= r_rd[PW-1:0];
                                r_bhop <= r_q_hop;
                            end
                            r_rd <= r_rd + 1'b1;
                            r_ph <= 1'b0;
                        end
                    end else begin
                        r_rd <= CW'(r_best);
                        r_state <= S_LIST;
                    end
                end
                S_LIST: begin
                    if (!r_ph) begin
                        r_ph <= 1'b1;
                    end else if (w_emit) begin
                        r_res <= mk(mrs_pkg::ST_OK, r_q_nh, r_q_hop, r_q_exp, r_n, w_lst);
                        r_ovalid <= 1'b1;
                        r_ph <= 1'b0;
                        if (w_lst) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_rd <= r_rd + 1'b1;
                        end
                    end
                end
                S_OUT: begin
                    if (w_emit) begin
                        r_ovalid <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule : mrs_engine
`default_nettype wire

### rtl/core/multipath_route_selector.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// multipath_route_selector
// multipath route table with expiry, add, remove, best path and listing
// ----------------------------------------------------------------------------
// Requests enter a two-entry queue and are carried out one at a time by a
// sequencer that walks one destination slot per cycle; path storage is read
// through a registered port, so each path slot is read before it is used. The
// next request starts only once the last result beat of the one before has
// been taken. A tick gives its beat from the output state; a lookup searches
// up to DEST_SLOTS slots, then sweeps the held paths to drop expired ones and
// gives the answer, and best sweeps the paths once more; an add of a new
// destination or a purge also sweeps every slot, and the add then searches up
// to DEST_SLOTS more for a free slot. List gives one result beat per path.
module multipath_route_selector #(
    parameter int unsigned DEST_SLOTS = 16,
    parameter int unsigned PATH_SLOTS = 4
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [2:0]  i_func,
    input  wire  [31:0] i_destination,
    input  wire  [31:0] i_next_hop,
    input  wire  [7:0]  i_hop_count,
    input  wire  [31:0] i_lifetime,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [1:0]  o_status,
    output logic [31:0] o_out_next_hop,
    output logic [7:0]  o_out_hop_count,
    output logic [47:0] o_out_expiry,
    output logic [2:0]  o_live_paths,
    output logic        o_last
);
    mrs_pkg::t_req w_in, w_q;
    mrs_pkg::t_res w_res;
    logic w_qv, w_qr;

    assign w_in.func        = mrs_pkg::t_func'(i_func);
    assign w_in.destination = i_destination;
    assign w_in.next_hop    = i_next_hop;
    assign w_in.hop_count   = i_hop_count;
    assign w_in.lifetime    = i_lifetime;

    mrs_req_fifo u_fifo (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_req(w_in),
        .o_valid(w_qv), .i_ready(w_qr), .o_req(w_q)
    );

    mrs_engine #(.DEST_SLOTS(DEST_SLOTS), .PATH_SLOTS(PATH_SLOTS)) u_engine (
        .i_clk, .i_rst_n, .i_valid(w_qv), .o_ready(w_qr), .i_req(w_q),
        .o_valid, .i_ready, .o_res(w_res)
    );

    assign o_status        = w_res.status;
    assign o_out_next_hop  = w_res.next_hop;
    assign o_out_hop_count = w_res.hop_count;
    assign o_out_expiry    = w_res.expiry;
    assign o_live_paths    = w_res.live_paths;
    assign o_last          = w_res.last;

`ifndef NO_ASSERTIONS
    a_live_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_live_paths <= 3'd4)) else $error("live paths out of range");
    a_full_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == mrs_pkg::ST_DEST_FULL) |-> (o_out_next_hop == '0))
        else $error("full status carries a path");
    a_nf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == mrs_pkg::ST_NOT_FOUND) |-> o_last)
        else $error("not found beat not last");
`endif
endmodule : multipath_route_selector
`default_nettype wire

### bench/multipath_route_selector_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multipath_route_selector_tb
// drives route table requests (tick, add, remove, best, has, list, purge and
// the unused code) with random idling on both channels, predicts every result
// beat from a behavioral route table and compares each beat field by field
// ----------------------------------------------------------------------------
module multipath_route_selector_tb;

    localparam int NDEST = 16;
    localparam int NPATH = 4;
    localparam int CYCLE_LIMIT = 600000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [2:0]  i_func = '0;
    logic [31:0] i_destination = '0;
    logic [31:0] i_next_hop = '0;
    logic [7:0]  i_hop_count = '0;
    logic [31:0] i_lifetime = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [1:0]  o_status;
    logic [31:0] o_out_next_hop;
    logic [7:0]  o_out_hop_count;
    logic [47:0] o_out_expiry;
    logic [2:0]  o_live_paths;
    logic        o_last;

    multipath_route_selector dut (.*);

    always #2 i_clk = ~i_clk;

    // route table copy
    logic [47:0] now_tick = '0;
    bit          slot_used [NDEST];
    logic [31:0] slot_addr [NDEST];
    int          slot_cnt  [NDEST];
    logic [31:0] p_nh  [NDEST][NPATH];
    logic [7:0]  p_hop [NDEST][NPATH];
    logic [47:0] p_exp [NDEST][NPATH];

    mrs_pkg::t_req req_queue [$];
    mrs_pkg::t_res beats_due [$];
    int   errors = 0;
    int   cycles = 0;
    bit   feeding_done = 0;
    bit   hold_sender = 0;
    int   rx_hold = 0;

    function automatic void queue_beat(mrs_pkg::t_res r);
        beats_due = {beats_due, r};
    endfunction

    function automatic void queue_req(mrs_pkg::t_req q);
        req_queue = {req_queue, q};
    endfunction

    function automatic mrs_pkg::t_res mk(logic [1:0] st, logic [31:0] nh, logic [7:0] hc,
                                         logic [47:0] ex, int live, bit lst);
        mrs_pkg::t_res r;
        r.status = st; r.next_hop = nh; r.hop_count = hc; r.expiry = ex;
        r.live_paths = live[2:0]; r.last = lst;
        return r;
    endfunction

    function automatic int find_slot(logic [31:0] a);
        for (int d = 0; d < NDEST; d++)
            if (slot_used[d] && slot_addr[d] == a) return d;
        return -1;
    endfunction

    function automatic int drop_expired(int d);
        int w;
        w = 0;
        for (int r = 0; r < slot_cnt[d]; r++)
            if (p_exp[d][r] > now_tick) begin
                p_nh[d][w] = p_nh[d][r]; p_hop[d][w] = p_hop[d][r];
                p_exp[d][w] = p_exp[d][r]; w++;
            end
        slot_cnt[d] = w;
        if (w == 0) slot_used[d] = 0;
        return w;
    endfunction

    function automatic void drop_expired_all();
        int x;
        for (int d = 0; d < NDEST; d++)
            if (slot_used[d]) x = drop_expired(d);
    endfunction

    function automatic void predict_route(mrs_pkg::t_req q);
        int d, n, p, w, b;
        logic [48:0] ex;
        d = (q.func >= mrs_pkg::FN_ADD && q.func <= mrs_pkg::FN_LIST) ?
            find_slot(q.destination) : -1;
        case (q.func)
            mrs_pkg::FN_TICK: begin
                if (now_tick != mrs_pkg::TICK_MAX) now_tick++;
                queue_beat(mk(mrs_pkg::ST_OK, 0, 0, now_tick, 0, 1));
            end
            mrs_pkg::FN_ADD: begin
                ex = {1'b0, now_tick} + q.lifetime;
                if (ex > mrs_pkg::TICK_MAX) ex = mrs_pkg::TICK_MAX;
                if (d < 0) begin
                    drop_expired_all();
                    for (d = 0; d < NDEST && slot_used[d]; d++) ;
                    if (d >= NDEST) begin
                        queue_beat(mk(mrs_pkg::ST_DEST_FULL, 0, 0, 0, 0, 1));
                        return;
                    end
                    slot_addr[d] = q.destination; slot_cnt[d] = 0;
                end else n = drop_expired(d);
                slot_used[d] = 1;
                n = slot_cnt[d];
                for (p = 0; p < n; p++) if (p_nh[d][p] == q.next_hop) break;
                if (p == n) begin
                    if (n >= NPATH) begin
                        queue_beat(mk(mrs_pkg::ST_PATH_FULL, 0, 0, 0, n, 1));
                        return;
                    end
                    p_nh[d][p] = q.next_hop; slot_cnt[d] = n + 1;
                end
                p_hop[d][p] = q.hop_count; p_exp[d][p] = ex[47:0];
                queue_beat(mk(mrs_pkg::ST_OK, q.next_hop, q.hop_count, ex[47:0],
                              slot_cnt[d], 1));
            end
            mrs_pkg::FN_REMOVE: begin
                if (d < 0) begin
                    queue_beat(mk(mrs_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 1));
                    return;
                end
                w = 0;
                for (p = 0; p < slot_cnt[d]; p++)
                    if (p_nh[d][p] != q.next_hop) begin
                        p_nh[d][w] = p_nh[d][p]; p_hop[d][w] = p_hop[d][p];
                        p_exp[d][w] = p_exp[d][p]; w++;
                    end
                slot_cnt[d] = w;
                n = drop_expired(d);
                queue_beat(mk(mrs_pkg::ST_OK, 0, 0, 0, n, 1));
            end
            mrs_pkg::FN_BEST, mrs_pkg::FN_HAS, mrs_pkg::FN_LIST: begin
                n = (d < 0) ? 0 : drop_expired(d);
                if (n == 0) queue_beat(mk(mrs_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 1));
                else if (q.func == mrs_pkg::FN_HAS)
                    queue_beat(mk(mrs_pkg::ST_OK, 0, 0, 0, n, 1));
                else if (q.func == mrs_pkg::FN_BEST) begin
                    b = 0;
                    for (p = 1; p < n; p++) if (p_hop[d][p] < p_hop[d][b]) b = p;
                    queue_beat(mk(mrs_pkg::ST_OK, p_nh[d][b], p_hop[d][b], p_exp[d][b],
                                  n, 1));
                end else
                    for (p = 0; p < n; p++)
                        queue_beat(mk(mrs_pkg::ST_OK, p_nh[d][p], p_hop[d][p],
                                      p_exp[d][p], n, p == n - 1));
            end
            mrs_pkg::FN_PURGE: begin
                drop_expired_all();
                queue_beat(mk(mrs_pkg::ST_OK, 0, 0, 0, 0, 1));
            end
            default: queue_beat(mk(mrs_pkg::ST_NOT_FOUND, 0, 0, 0, 0, 1));
        endcase
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h expected %0h", what, got, want);
        errors++;
    endtask

    function automatic mrs_pkg::t_req mkreq(mrs_pkg::t_func f, logic [31:0] dst,
                                            logic [31:0] nh, logic [7:0] hc,
                                            logic [31:0] lt);
        mrs_pkg::t_req q;
        q.func = f; q.destination = dst; q.next_hop = nh; q.hop_count = hc;
        q.lifetime = lt;
        return q;
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // handshake seen at the last rising edge
    bit o_ready_seen = 0;
    always @(posedge i_clk) o_ready_seen <= i_valid && o_ready;

    // driver
    int tx_gap = 0;
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready_seen) begin
                predict_route(mrs_pkg::t_req'({i_func, i_destination, i_next_hop,
                                               i_hop_count, i_lifetime}));
            end
            if (!i_valid || o_ready_seen) begin
                if (tx_gap > 0) begin
                    tx_gap--; i_valid <= 1'b0;
                end else if (req_queue.size() > 0 && !hold_sender) begin
                    {i_func, i_destination, i_next_hop, i_hop_count, i_lifetime}
                        <= req_queue.pop_front();
                    i_valid <= 1'b1;
                    tx_gap = gap_len();
                end else i_valid <= 1'b0;
            end
        end
    end

    // monitor
    mrs_pkg::t_res want;
    int rx_gap = 0;
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("multipath_route_selector_tb: FAIL");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) begin
            if (beats_due.size() == 0) begin
                report_mismatch("unexpected beat", o_status, 0);
            end else begin
                want = beats_due.pop_front();
                if (o_status !== want.status) report_mismatch("status", o_status, want.status);
                if (o_out_next_hop !== want.next_hop)
                    report_mismatch("next_hop", o_out_next_hop, want.next_hop);
                if (o_out_hop_count !== want.hop_count)
                    report_mismatch("hop_count", o_out_hop_count, want.hop_count);
                if (o_out_expiry !== want.expiry)
                    report_mismatch("expiry", o_out_expiry, want.expiry);
                if (o_live_paths !== want.live_paths)
                    report_mismatch("live_paths", o_live_paths, want.live_paths);
                if (o_last !== want.last) report_mismatch("last", o_last, want.last);
            end
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--; i_ready <= 1'b0;
        end else if (rx_gap > 0) begin
            rx_gap--; i_ready <= 1'b0;
        end else begin
            i_ready <= i_rst_n;
            rx_gap = gap_len();
        end
    end

    function automatic logic [31:0] pick_dst();
        return ($urandom_range(0, 9) == 0) ? $urandom : 32'h0A000000 + $urandom_range(0, 19);
    endfunction

    function automatic logic [31:0] pick_life();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 32'hFFFFFFFF;
            2: return $urandom;
            default: return $urandom_range(1, 30);
        endcase
    endfunction

    task automatic wait_drained();
        while (req_queue.size() > 0 || i_valid || beats_due.size() > 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    initial begin
        int f, drain;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;
        // directed
        queue_req(mkreq(mrs_pkg::FN_BEST, 32'h0, 0, 0, 0));
        queue_req(mkreq(mrs_pkg::FN_ADD, 32'h0, 32'h0, 8'h00, 32'h0));
        queue_req(mkreq(mrs_pkg::FN_HAS, 32'h0, 0, 0, 0));
        queue_req(mkreq(mrs_pkg::FN_ADD, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 32'hFFFFFFFF));
        for (int i = 0; i < 5; i++)
            queue_req(mkreq(mrs_pkg::FN_ADD, 32'h55AA55AA, 32'h100 + i, 8'd9 - i, 5 + i));
        queue_req(mkreq(mrs_pkg::FN_ADD, 32'h55AA55AA, 32'h101, 8'd1, 32'd50));
        queue_req(mkreq(mrs_pkg::FN_LIST, 32'h55AA55AA, 0, 0, 0));
        queue_req(mkreq(mrs_pkg::FN_BEST, 32'h55AA55AA, 0, 0, 0));
        queue_req(mkreq(mrs_pkg::FN_REMOVE, 32'h55AA55AA, 32'h100, 0, 0));
        queue_req(mkreq(mrs_pkg::FN_REMOVE, 32'h12345678, 32'h100, 0, 0));
        for (int i = 0; i < 6; i++) queue_req(mkreq(mrs_pkg::FN_TICK, 0, 0, 0, 0));
        queue_req(mkreq(mrs_pkg::FN_LIST, 32'h55AA55AA, 0, 0, 0));
        queue_req(mkreq(mrs_pkg::FN_PURGE, 0, 0, 0, 0));
        queue_req(mkreq(mrs_pkg::FN_NONE, 32'hFFFFFFFF, 32'hFFFFFFFF, 8'hFF, 32'hFFFFFFFF));
        wait_drained();
        // fill the destination table, then one more
        for (int i = 0; i < 17; i++)
            queue_req(mkreq(mrs_pkg::FN_ADD, 32'hC0000000 + i, i, i, 32'd40));
        queue_req(mkreq(mrs_pkg::FN_LIST, 32'hC0000003, 0, 0, 0));
        rx_hold = 400;
        wait_drained();
        // random
        for (int i = 0; i < 340; i++) begin
            f = $urandom_range(0, 99);
            if (f < 40) f = mrs_pkg::FN_ADD;
            else if (f < 55) f = mrs_pkg::FN_TICK;
            else if (f < 65) f = mrs_pkg::FN_BEST;
            else if (f < 72) f = mrs_pkg::FN_HAS;
            else if (f < 82) f = mrs_pkg::FN_LIST;
            else if (f < 90) f = mrs_pkg::FN_REMOVE;
            else if (f < 96) f = mrs_pkg::FN_PURGE;
            else f = mrs_pkg::FN_NONE;
            queue_req(mkreq(mrs_pkg::t_func'(f[2:0]), pick_dst(),
                ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 5),
                $urandom, pick_life()));
            if (i == 150) begin
                rx_hold = 500;
            end
            if (i == 250) begin
                hold_sender = 1;
                while (i_valid || beats_due.size() > 0)
                    @(posedge i_clk);
                hold_sender = 0;
            end
        end
        while (req_queue.size() > 0 || i_valid) @(posedge i_clk);
        drain = 0;
        while (beats_due.size() > 0 && drain < 100000) begin
            @(posedge i_clk); drain++;
        end
        repeat (300) @(posedge i_clk);
        if (errors == 0 && beats_due.size() == 0)
            $display("multipath_route_selector_tb: PASS");
        else
            $display("multipath_route_selector_tb: FAIL");
        $finish;
    end
endmodule
